// ===== hw/rtl/dms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dms_pkg: shared types and constants of the minimizer sketcher
// Request structs, window slot type, ring control and the base decoder.
// ----------------------------------------------------------------------------
package dms_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 32;
  localparam int unsigned KMER_MAX       = 28;
  localparam int unsigned HASH_W         = 56;
  localparam int unsigned TAG_W          = 49;
  localparam int unsigned POS_W          = 48;
  localparam int unsigned MAX_RESULTS    = 64;
  localparam int unsigned CFG_ADDR_W     = 3;

  localparam logic [5:0] WINDOW_LEN_RST = 6'd10;
  localparam logic [4:0] KMER_LEN_RST   = 5'd15;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_LEN = 1'b0;
  localparam logic REG_KMER_LEN   = 1'b1;

  localparam logic [2:0] BASE_NONE = 3'd4;

  typedef struct packed {
    logic [7:0]       base_char;
    logic             first_base;
    logic             last_base;
    logic [POS_W-1:0] read_offset;
  } in_item_t;

  typedef struct packed {
    logic [HASH_W-1:0] minimizer_hash;
    logic [TAG_W-1:0]  position_tag;
    logic              last_in_run;
  } out_item_t;

  // one extra top bit each: an empty slot is all ones and sorts above any hash
  typedef struct packed {
    logic [HASH_W:0] hash;
    logic [TAG_W:0]  tag;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '1;

  typedef struct packed {
    logic clear;
    logic shift;
  } ring_ctl_t;

  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      8'd0, 8'h41, 8'h61:        code = 3'd0;
      8'd1, 8'h43, 8'h63:        code = 3'd1;
      8'd2, 8'h47, 8'h67:        code = 3'd2;
      8'd3, 8'h54, 8'h74,
      8'h55, 8'h75:              code = 3'd3;
      default:                   code = BASE_NONE;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dms_slot_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dms_slot_cell: one window slot of the ring
// Holds a (hash, tag) pair; clears, loads a new k-mer or takes its neighbour.
// ----------------------------------------------------------------------------
module dms_slot_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dms_pkg::ring_ctl_t ctl,
  input  logic              wr_en,
  input  dms_pkg::slot_t    wr_data,
  input  dms_pkg::slot_t    nbr_data,
  output dms_pkg::slot_t    slot_data
);
  import dms_pkg::*;

  slot_t slot_r, slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.clear) begin
      slot_nxt = SLOT_EMPTY;
    end else if (ctl.shift) begin
      slot_nxt = nbr_data;
    end else if (wr_en) begin
      slot_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_EMPTY;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_data = slot_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dms_hash_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dms_hash_mix: invertible masked k-mer hash
// Four rounds, one round a cycle: three add-and-xorshift rounds, then a final add; done pulses with the hash.
// ----------------------------------------------------------------------------
module dms_hash_mix (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dms_pkg::HASH_W-1:0] kmer,
  input  logic [dms_pkg::HASH_W-1:0] mask,
  output logic                       done,
  output logic [dms_pkg::HASH_W-1:0] hash
);
  import dms_pkg::*;

  logic [HASH_W-1:0] v_r, v_nxt, m_r, t;
  logic [1:0]        round_r;
  logic              busy_r, done_r;

  always_comb begin
    t     = '0;
    v_nxt = v_r;
    case (round_r)
      2'd0: begin
        t     = (~v_r + (v_r << 21)) & m_r;
        v_nxt = t ^ (t >> 24);
      end
      2'd1: begin
        t     = (v_r + (v_r << 3) + (v_r << 8)) & m_r;
        v_nxt = t ^ (t >> 14);
      end
      2'd2: begin
        t     = (v_r + (v_r << 2) + (v_r << 4)) & m_r;
        v_nxt = t ^ (t >> 28);
      end
      default: begin
        v_nxt = (v_r + (v_r << 31)) & m_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      round_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        round_r <= '0;
      end else if (busy_r) begin
        round_r <= round_r + 2'd1;
        if (round_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= kmer;
      m_r <= mask;
    end else if (busy_r) begin
      v_r <= v_nxt;
    end
  end

  assign done = done_r;
  assign hash = v_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dna_minimizer_sketcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dna_minimizer_sketcher: symmetric (w,k)-minimizer sketcher, one base a request
// K-mer tracking, hash unit and a rotating ring of window slot cells.
// ----------------------------------------------------------------------------
//  channel | ports                              | moves
//  in      | in_valid, in_stall, in_data        | one sequence character
//  out     | out_valid, out_stall, out_data     | one minimizer (hash, tag)
//  config  | psel, penable, pwrite, paddr, ...  | window_len @0, kmer_len @4
//
//  A hashed base goes from accept through decode, the four hash rounds,
//  write, update, flush and end to the next accept. A base with no hash
//  skips the hash rounds; a symmetric one goes from decode to flush. A
//  window pass (tie emission or minimum rescan) rotates the ring twice
//  round, and the rescan may add a tie pass.
//  Reset is synchronous; all slots come out of reset empty (all ones).
//  A stalled result holds the sequencer only when a further result waits.
// ----------------------------------------------------------------------------
module dna_minimizer_sketcher #(
  parameter int unsigned WINDOW_MAX = dms_pkg::WINDOW_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dms_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dms_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dms_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import dms_pkg::*;

  localparam int unsigned SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned WW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned VW = $clog2(WINDOW_MAX + KMER_MAX + 1);
  localparam int unsigned CW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FRONT, S_MIX, S_WRITE, S_SCAN, S_UPD, S_FLUSH, S_END
  } state_t;

  typedef enum logic [1:0] {
    SCAN_TIES_A, SCAN_RESCAN, SCAN_TIES_B
  } scan_t;

  state_t            state_r, state_nxt;
  scan_t             scan_mode_r, scan_mode_nxt;
  logic [SW-1:0]     scan_slot_r, scan_slot_nxt;
  logic              scan_rev_r, scan_rev_nxt;
  in_item_t          item_r, item_nxt;
  logic [HASH_W-1:0] fk_r, fk_nxt, rk_r, rk_nxt;
  logic [VW-1:0]     vr_r, vr_nxt;
  logic [POS_W-1:0]  bidx_r, bidx_nxt, soff_r, soff_nxt;
  slot_t             entry_r, entry_nxt, min_r, min_nxt, pend_r, pend_nxt;
  logic [SW-1:0]     min_slot_r, min_slot_nxt, wslot_r, wslot_nxt;
  logic              pend_v_r, pend_v_nxt, out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [5:0]        win_len_r, win_len_nxt;
  logic [4:0]        kmer_len_r, kmer_len_nxt;

  logic [WW-1:0]     w_eff, wnext, slot_w, bp_w;
  logic [4:0]        k_eff;
  logic [HASH_W-1:0] mask;
  logic [VW-1:0]     sat, sat_m1, vr_base, vr_inc;
  logic [HASH_W-1:0] fk_base, rk_base, fk_new, rk_new;
  logic [POS_W-1:0]  bidx_base, soff_base, tag_sum;
  logic [2:0]        code;
  logic              sym, strand;
  logic [SW-1:0]     wslot_adv;

  logic              mix_start, mix_done;
  logic [HASH_W-1:0] mix_hash;

  ring_ctl_t         ring_ctl;
  logic              ring_wr;
  slot_t             slot_q [WINDOW_MAX];
  slot_t             head;

  logic              in_range, scan_last;
  logic              emit_want, emit_ok, emit_do, emit_block, can_emit, out_free;
  slot_t             emit_data;
  logic              push_end, cfg_wr;

  // --------------------------------------------------------------------------
  // effective configuration
  always_comb begin
    if (win_len_r == '0) begin
      w_eff = WW'(1);
    end else if (win_len_r > 6'(WINDOW_MAX)) begin
      w_eff = WW'(WINDOW_MAX);
    end else begin
      w_eff = WW'(win_len_r);
    end
    if (kmer_len_r == '0) begin
      k_eff = 5'd1;
    end else if (kmer_len_r > 5'(KMER_MAX)) begin
      k_eff = 5'(KMER_MAX);
    end else begin
      k_eff = kmer_len_r;
    end
  end

  assign mask   = ~({HASH_W{1'b1}} << {k_eff, 1'b0});
  assign sat    = VW'(w_eff) + VW'(k_eff);
  assign sat_m1 = sat - VW'(1);

  // --------------------------------------------------------------------------
  // k-mer front end, on the state as cleared by a first base
  always_comb begin
    fk_base   = item_r.first_base ? '0 : fk_r;
    rk_base   = item_r.first_base ? '0 : rk_r;
    vr_base   = item_r.first_base ? '0 : vr_r;
    bidx_base = item_r.first_base ? '0 : bidx_r;
    soff_base = item_r.first_base ? item_r.read_offset : soff_r;
    code      = base_code(item_r.base_char);
    fk_new    = ((fk_base << 2) | HASH_W'(code[1:0])) & mask;
    rk_new    = ((rk_base >> 2) | (HASH_W'(~code[1:0]) << {k_eff - 5'd1, 1'b0})) & mask;
    sym       = (fk_new == rk_new);
    strand    = !(fk_new < rk_new);
    vr_inc    = (vr_base < sat) ? vr_base + VW'(1) : sat;
    tag_sum   = soff_base + bidx_base;
  end

  assign wnext     = WW'(wslot_r) + WW'(1);
  assign wslot_adv = (wnext >= w_eff) ? '0 : SW'(wnext);

  dms_hash_mix u_mix (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mix_start),
    .kmer (strand ? rk_new : fk_new),
    .mask (mask),
    .done (mix_done),
    .hash (mix_hash)
  );

  // --------------------------------------------------------------------------
  // window ring: cell i takes cell i+1, so after t shifts cell 0 shows slot t
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    localparam int unsigned NB = (i + 1) % WINDOW_MAX;
    dms_slot_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ring_ctl),
      .wr_en    (ring_wr && (wslot_r == SW'(i))),
      .wr_data  (entry_r),
      .nbr_data (slot_q[NB]),
      .slot_data(slot_q[i])
    );
  end

  assign head = slot_q[0];

  always_comb begin
    slot_w    = WW'(scan_slot_r);
    bp_w      = WW'(wslot_r);
    scan_last = scan_rev_r && (scan_slot_r == SW'(WINDOW_MAX - 1));
    if (!scan_rev_r) begin
      in_range = (slot_w > bp_w) && (slot_w < w_eff);
    end else if (scan_mode_r == SCAN_TIES_A) begin
      in_range = slot_w < bp_w;
    end else begin
      in_range = slot_w <= bp_w;
    end
  end

  // --------------------------------------------------------------------------
  // which request the current state wants to send
  always_comb begin
    emit_want = 1'b0;
    emit_data = min_r;
    case (state_r)
      S_UPD: begin
        if (entry_r.hash <= min_r.hash) begin
          emit_want = vr_r >= sat;
        end else if (wslot_r == min_slot_r) begin
          emit_want = vr_r >= sat_m1;
        end
      end
      S_SCAN: begin
        emit_data = head;
        if (scan_mode_r != SCAN_RESCAN) begin
          emit_want = in_range && (head.hash == min_r.hash) && (head.tag != min_r.tag);
        end
      end
      S_FLUSH: begin
        emit_want = item_r.last_base && (min_r.hash != SLOT_EMPTY.hash);
      end
      default: begin
        emit_want = 1'b0;
      end
    endcase
  end

  assign out_free   = !out_valid_r || !out_stall;
  assign can_emit   = !pend_v_r || out_free;
  assign emit_ok    = cnt_r < CW'(MAX_RESULTS);
  assign emit_do    = emit_want && emit_ok && can_emit;
  assign emit_block = emit_want && emit_ok && !can_emit;
  assign cfg_wr     = psel && penable && pwrite;

  // --------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_nxt     = state_r;
    scan_mode_nxt = scan_mode_r;
    scan_slot_nxt = scan_slot_r;
    scan_rev_nxt  = scan_rev_r;
    item_nxt      = item_r;
    fk_nxt        = fk_r;
    rk_nxt        = rk_r;
    vr_nxt        = vr_r;
    bidx_nxt      = bidx_r;
    soff_nxt      = soff_r;
    entry_nxt     = entry_r;
    min_nxt       = min_r;
    min_slot_nxt  = min_slot_r;
    wslot_nxt     = wslot_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    cnt_nxt       = cnt_r;
    win_len_nxt   = win_len_r;
    kmer_len_nxt  = kmer_len_r;
    mix_start     = 1'b0;
    ring_ctl      = '0;
    ring_wr       = 1'b0;
    push_end      = 1'b0;

    if (cfg_wr) begin
      unique case (paddr[2])
        REG_WINDOW_LEN: win_len_nxt  = pwdata[5:0];
        REG_KMER_LEN:   kmer_len_nxt = pwdata[4:0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          cnt_nxt   = '0;
          state_nxt = S_FRONT;
        end
      end
      S_FRONT: begin
        if (item_r.first_base) begin
          soff_nxt       = item_r.read_offset;
          min_nxt        = SLOT_EMPTY;
          min_slot_nxt   = '0;
          wslot_nxt      = '0;
          ring_ctl.clear = 1'b1;
        end
        bidx_nxt  = bidx_base + POS_W'(1);
        entry_nxt = SLOT_EMPTY;
        if (code == BASE_NONE) begin
          vr_nxt    = '0;
          fk_nxt    = fk_base;
          rk_nxt    = rk_base;
          state_nxt = S_WRITE;
        end else begin
          fk_nxt = fk_new;
          rk_nxt = rk_new;
          if (sym) begin
            // symmetric k-mer: leave the window alone
            vr_nxt    = vr_base;
            state_nxt = S_FLUSH;
          end else begin
            vr_nxt = vr_inc;
            if (vr_inc >= VW'(k_eff)) begin
              entry_nxt.tag = {1'b0, tag_sum, strand};
              mix_start     = 1'b1;
              state_nxt     = S_MIX;
            end else begin
              state_nxt = S_WRITE;
            end
          end
        end
      end
      S_MIX: begin
        if (mix_done) begin
          entry_nxt.hash = {1'b0, mix_hash};
          state_nxt      = S_WRITE;
        end
      end
      S_WRITE: begin
        ring_wr = 1'b1;
        if (vr_r == sat_m1) begin
          scan_mode_nxt = SCAN_TIES_A;
          scan_slot_nxt = '0;
          scan_rev_nxt  = 1'b0;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (entry_r.hash <= min_r.hash) begin
          if (!emit_block) begin
            min_nxt      = entry_r;
            min_slot_nxt = wslot_r;
            wslot_nxt    = wslot_adv;
            state_nxt    = S_FLUSH;
          end
        end else if (wslot_r == min_slot_r) begin
          // minimum leaves the window: search the ring again
          if (!emit_block) begin
            min_nxt.hash  = SLOT_EMPTY.hash;
            scan_mode_nxt = SCAN_RESCAN;
            scan_slot_nxt = '0;
            scan_rev_nxt  = 1'b0;
            state_nxt     = S_SCAN;
          end
        end else begin
          wslot_nxt = wslot_adv;
          state_nxt = S_FLUSH;
        end
      end
      S_SCAN: begin
        if (scan_mode_r == SCAN_RESCAN && in_range && (min_r.hash >= head.hash)) begin
          min_nxt      = head;
          min_slot_nxt = scan_slot_r;
        end
        if (!emit_block) begin
          ring_ctl.shift = 1'b1;
          if (scan_slot_r == SW'(WINDOW_MAX - 1)) begin
            scan_slot_nxt = '0;
            scan_rev_nxt  = !scan_rev_r;
          end else begin
            scan_slot_nxt = scan_slot_r + SW'(1);
          end
          if (scan_last) begin
            unique case (scan_mode_r)
              SCAN_TIES_A: state_nxt = S_UPD;
              SCAN_RESCAN: begin
                if (vr_r >= sat_m1) begin
                  scan_mode_nxt = SCAN_TIES_B;
                end else begin
                  wslot_nxt = wslot_adv;
                  state_nxt = S_FLUSH;
                end
              end
              default: begin
                wslot_nxt = wslot_adv;
                state_nxt = S_FLUSH;
              end
            endcase
          end
        end
      end
      S_FLUSH: begin
        if (!emit_block) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push_end  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold one request back so the last one of a base can be marked
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (emit_do) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = {pend_r.hash[HASH_W-1:0], pend_r.tag[TAG_W-1:0], 1'b0};
      end
      pend_nxt   = emit_data;
      pend_v_nxt = 1'b1;
      cnt_nxt    = cnt_r + CW'(1);
    end
    if (push_end) begin
      out_valid_nxt = 1'b1;
      out_nxt       = {pend_r.hash[HASH_W-1:0], pend_r.tag[TAG_W-1:0], 1'b1};
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_mode_r <= SCAN_TIES_A;
      scan_slot_r <= '0;
      scan_rev_r  <= 1'b0;
      fk_r        <= '0;
      rk_r        <= '0;
      vr_r        <= '0;
      bidx_r      <= '0;
      soff_r      <= '0;
      min_r       <= SLOT_EMPTY;
      min_slot_r  <= '0;
      wslot_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      win_len_r   <= WINDOW_LEN_RST;
      kmer_len_r  <= KMER_LEN_RST;
    end else begin
      state_r     <= state_nxt;
      scan_mode_r <= scan_mode_nxt;
      scan_slot_r <= scan_slot_nxt;
      scan_rev_r  <= scan_rev_nxt;
      fk_r        <= fk_nxt;
      rk_r        <= rk_nxt;
      vr_r        <= vr_nxt;
      bidx_r      <= bidx_nxt;
      soff_r      <= soff_nxt;
      min_r       <= min_nxt;
      min_slot_r  <= min_slot_nxt;
      wslot_r     <= wslot_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      win_len_r   <= win_len_nxt;
      kmer_len_r  <= kmer_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    entry_r <= entry_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LEN: prdata = {26'd0, win_len_r};
      REG_KMER_LEN:   prdata = {27'd0, kmer_len_r};
    endcase
  end

`ifndef SYNTHESIS
  a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (cnt_r != '0))
    else $error("held request without an emit count");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("request left behind at end of base");

  a_mix_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mix_done |-> (state_r == S_MIX))
    else $error("hash finished outside the hash wait");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RESULTS))
    else $error("too many requests for one base");
`endif

endmodule
`default_nettype wire

// ===== tb/dna_minimizer_sketcher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_minimizer_sketcher_checker: minimizer prediction and result comparison
// Watches the config port and both channels, recomputes the k-mer, hash and
// window state for each accepted request and compares every result in order.
// ----------------------------------------------------------------------------
module dna_minimizer_sketcher_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  dms_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  dms_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [dms_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output int                             errors,
  output int                             pending
);
  import dms_pkg::*;

  localparam logic [63:0] ONES   = '1;
  localparam logic [63:0] MSK48  = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MSK49  = 64'h1_FFFF_FFFF_FFFF;
  localparam int unsigned SLOTS  = 32;
  localparam logic [2:0]  NO_BASE = 3'd4;

  logic [5:0]  win_len;
  logic [4:0]  kmer_len;
  logic [63:0] fwd_kmer, rev_kmer;
  int unsigned run_len;
  logic [63:0] slot_hash [SLOTS];
  logic [63:0] slot_tag  [SLOTS];
  logic [63:0] min_hash, min_tag;
  int unsigned min_slot, wr_slot;
  logic [47:0] base_idx, read_start;

  out_item_t minimizer_q[$];
  out_item_t step_res[$];

  function automatic logic [2:0] decode_char(input logic [7:0] ch);
    case (ch)
      8'd0, "A", "a":           return 3'd0;
      8'd1, "C", "c":           return 3'd1;
      8'd2, "G", "g":           return 3'd2;
      8'd3, "T", "t", "U", "u": return 3'd3;
      default:                  return NO_BASE;
    endcase
  endfunction

  function automatic logic [63:0] scramble(input logic [63:0] v, input logic [63:0] m);
    v = (~v + (v << 21)) & m;
    v = v ^ (v >> 24);
    v = (v + (v << 3) + (v << 8)) & m;
    v = v ^ (v >> 14);
    v = (v + (v << 2) + (v << 4)) & m;
    v = v ^ (v >> 28);
    v = (v + (v << 31)) & m;
    return v;
  endfunction

  task automatic clear_read();
    fwd_kmer = '0;
    rev_kmer = '0;
    run_len  = 0;
    for (int j = 0; j < SLOTS; j++) begin
      slot_hash[j] = ONES;
      slot_tag[j]  = ONES;
    end
    min_hash = ONES;
    min_tag  = ONES;
    min_slot = 0;
    wr_slot  = 0;
    base_idx = '0;
  endtask

  task automatic push_result(input logic [63:0] h, input logic [63:0] t);
    out_item_t r;
    if (step_res.size() < MAX_RESULTS) begin
      r.minimizer_hash = h[HASH_W-1:0];
      r.position_tag   = t[TAG_W-1:0];
      r.last_in_run    = 1'b0;
      step_res.push_back(r);
    end
  endtask

  // ties with the current minimum, from slot 'from' round to just before 'upto'
  task automatic push_ties(input int unsigned from, input int unsigned upto,
                           input int unsigned w);
    for (int unsigned j = from; j < w; j++)
      if (slot_hash[j] == min_hash && slot_tag[j] != min_tag)
        push_result(slot_hash[j], slot_tag[j]);
    for (int unsigned j = 0; j < upto && j < SLOTS; j++)
      if (slot_hash[j] == min_hash && slot_tag[j] != min_tag)
        push_result(slot_hash[j], slot_tag[j]);
  endtask

  task automatic sketch_base(input in_item_t it);
    int unsigned w, k, sat, bp;
    logic [63:0] mask, hv, tv, pos;
    logic [2:0]  c;
    bit          skip, z;
    w = win_len;
    k = kmer_len;
    if (w < 1) w = 1;
    if (w > SLOTS) w = SLOTS;
    if (k < 1) k = 1;
    if (k > KMER_MAX) k = KMER_MAX;
    mask = (64'd1 << (2 * k)) - 64'd1;
    sat  = w + k;
    hv   = ONES;
    tv   = ONES;
    skip = 0;
    step_res.delete();

    if (it.first_base) begin
      clear_read();
      read_start = it.read_offset;
    end
    pos = 64'(base_idx);
    c   = decode_char(it.base_char);

    if (c != NO_BASE) begin
      fwd_kmer = ((fwd_kmer << 2) | 64'(c)) & mask;
      rev_kmer = ((rev_kmer >> 2) | (64'(3 ^ c) << (2 * (k - 1)))) & mask;
      if (fwd_kmer == rev_kmer) begin
        skip = 1;
      end else begin
        z = !(fwd_kmer < rev_kmer);
        run_len = (run_len < sat) ? run_len + 1 : sat;
        if (run_len >= k) begin
          hv = scramble(z ? rev_kmer : fwd_kmer, mask);
          tv = ((((64'(read_start) + pos) & MSK49) << 1) | 64'(z)) & MSK49;
        end
      end
    end else begin
      run_len = 0;
    end

    if (!skip) begin
      bp = wr_slot & (SLOTS - 1);
      slot_hash[bp] = hv;
      slot_tag[bp]  = tv;
      if (run_len == sat - 1) push_ties(bp + 1, bp, w);
      if (hv <= min_hash) begin
        if (run_len >= sat) push_result(min_hash, min_tag);
        min_hash = hv;
        min_tag  = tv;
        min_slot = bp;
      end else if (bp == min_slot) begin
        if (run_len >= sat - 1) push_result(min_hash, min_tag);
        // rescan the window oldest first; later equal entries win
        min_hash = ONES;
        for (int unsigned j = bp + 1; j < w; j++)
          if (min_hash >= slot_hash[j]) begin
            min_hash = slot_hash[j]; min_tag = slot_tag[j]; min_slot = j;
          end
        for (int unsigned j = 0; j <= bp; j++)
          if (min_hash >= slot_hash[j]) begin
            min_hash = slot_hash[j]; min_tag = slot_tag[j]; min_slot = j;
          end
        if (run_len >= sat - 1) push_ties(bp + 1, bp + 1, w);
      end
      wr_slot = (bp + 1 >= w) ? 0 : bp + 1;
    end

    base_idx = base_idx + 48'd1;

    if (it.last_base && min_hash != ONES) push_result(min_hash, min_tag);

    if (step_res.size() > 0) step_res[step_res.size() - 1].last_in_run = 1'b1;
    foreach (step_res[i]) minimizer_q.push_back(step_res[i]);
  endtask

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      win_len    = WINDOW_LEN_RST;
      kmer_len   = KMER_LEN_RST;
      clear_read();
      read_start = '0;
      minimizer_q.delete();
      errors     = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WINDOW_LEN) win_len = pwdata[5:0];
        else                            kmer_len = pwdata[4:0];
      end
      if (in_valid && !in_stall) sketch_base(in_data);
      if (out_valid && !out_stall) begin
        if (minimizer_q.size() == 0) begin
          report($sformatf("unexpected result hash %h tag %h",
                           out_data.minimizer_hash, out_data.position_tag));
        end else begin
          exp_r = minimizer_q.pop_front();
          if (out_data.minimizer_hash != exp_r.minimizer_hash)
            report($sformatf("hash %h, expected %h",
                             out_data.minimizer_hash, exp_r.minimizer_hash));
          if (out_data.position_tag != exp_r.position_tag)
            report($sformatf("tag %h, expected %h",
                             out_data.position_tag, exp_r.position_tag));
          if (out_data.last_in_run != exp_r.last_in_run)
            report($sformatf("last_in_run %b, expected %b",
                             out_data.last_in_run, exp_r.last_in_run));
        end
      end
    end
    pending = minimizer_q.size();
  end

endmodule

// ===== tb/dna_minimizer_sketcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_minimizer_sketcher_test: stimulus and verdict for the minimizer sketcher
// Random reads at reset settings, directed reads, then reads, repeats and noise
// over several window and k-mer settings; random input gaps and result stalls.
// ----------------------------------------------------------------------------
module dna_minimizer_sketcher_test;
  import dms_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 300;
  localparam int PHASE_ITEMS = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    errors, pending;

  bit calm_in, calm_out;
  int sent, idle_cycles, stall_left;
  bit stall_on;

  dna_minimizer_sketcher dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dna_minimizer_sketcher_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result stalls: mostly short bursts, a few long ones, and calm stretches
  always @(posedge clk) begin
    if (!rst_n || calm_out) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0; stall_left <= $urandom_range(0, 8);
      end else if (r < 90) begin
        out_stall <= 1'b1; stall_left <= $urandom_range(0, 3);
      end else if (r < 96) begin
        out_stall <= 1'b1; stall_left <= $urandom_range(15, 70);
      end else begin
        out_stall <= 1'b0; stall_left <= $urandom_range(80, 200);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("dna_minimizer_sketcher_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_base(input logic [7:0] ch, input bit first, input bit last,
                           input logic [47:0] offset);
    int gap;
    in_valid           <= 1'b1;
    in_data.base_char  <= ch;
    in_data.first_base <= first;
    in_data.last_base  <= last;
    in_data.read_offset <= offset;
    do @(posedge clk); while (in_stall);
    sent++;
    if (calm_in) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, 99);
      gap = (gap < 55) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold until every expected result is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [7:0] random_nt(input int alpha);
    case ($urandom_range(0, 3) % alpha)
      0: return ($urandom_range(0, 3) == 0) ? 8'd0 : ($urandom_range(0, 1) ? "A" : "a");
      1: return ($urandom_range(0, 3) == 0) ? 8'd1 : ($urandom_range(0, 1) ? "C" : "c");
      2: return ($urandom_range(0, 3) == 0) ? 8'd2 : ($urandom_range(0, 1) ? "G" : "g");
      default: begin
        case ($urandom_range(0, 4))
          0: return 8'd3;
          1: return "T";
          2: return "t";
          3: return "U";
          default: return "u";
        endcase
      end
    endcase
  endfunction

  function automatic logic [47:0] random_offset();
    case ($urandom_range(0, 3))
      0: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 50));
      1: return 48'($urandom_range(0, 1000));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic random_read();
    int          len, period, alpha;
    bit          first;
    logic [7:0]  pat [8];
    logic [7:0]  ch;
    logic [47:0] offset;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 25);
    period = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    alpha  = ($urandom_range(0, 4) == 0) ? 2 : 4;
    first  = ($urandom_range(0, 9) != 0);
    offset = random_offset();
    foreach (pat[i]) pat[i] = random_nt(alpha);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 39) == 0) ch = 8'($urandom());
      else if (period > 0)            ch = pat[i % period];
      else                            ch = random_nt(alpha);
      send_base(ch, first && i == 0, i == len - 1, offset);
    end
  endtask

  task automatic random_phase(input int items);
    int start;
    start    = sent;
    calm_in  = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    while (sent - start < items) begin
      if ($urandom_range(0, 6) == 0)
        send_base(8'($urandom()), 1'($urandom()), 1'($urandom()),
                  {$urandom(), $urandom()});
      else
        random_read();
    end
    drain();
  endtask

  task automatic send_string(input string s, input bit first, input bit last_at_end,
                             input logic [47:0] offset);
    for (int i = 0; i < s.len(); i++)
      send_base(s[i], first && i == 0, last_at_end && i == s.len() - 1, offset);
  endtask

  initial begin
    logic [5:0] win_set [8];
    logic [4:0] kmer_set [8];
    win_set  = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd7, 6'd5, 6'd20, 6'd2};
    kmer_set = '{5'd1, 5'd28, 5'd0, 5'd31, 5'd4, 5'd11, 5'd3, 5'd2};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    sent     = 0;
    calm_in  = 1'b0;
    calm_out = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings first, a random phase of reads and noise
    random_phase(30);

    cfg_write(REG_WINDOW_LEN, 32'd3);
    cfg_write(REG_KMER_LEN, 32'd2);
    // every code and case, ambiguous bytes, tag wrap at the top offset
    send_base("A", 1'b1, 1'b0, 48'hFFFF_FFFF_FFFF);
    send_string("CGTacgtUu", 1'b0, 1'b0, 48'd0);
    send_base(8'd0, 1'b0, 1'b0, 48'd0);
    send_base(8'd1, 1'b0, 1'b0, 48'd0);
    send_base(8'd2, 1'b0, 1'b0, 48'd0);
    send_base(8'd3, 1'b0, 1'b1, 48'd0);
    send_base("N", 1'b0, 1'b0, 48'd0);
    send_base(8'hFF, 1'b0, 1'b0, 48'd0);
    // symmetric k-mer, last base landing on it
    send_string("AT", 1'b1, 1'b1, 48'd5);
    // repeats give equal hashes in the window
    send_string("ACACACAC", 1'b1, 1'b1, 48'd100);
    drain();

    foreach (win_set[p]) begin
      cfg_write(REG_WINDOW_LEN, {26'($urandom()), win_set[p]});
      cfg_write(REG_KMER_LEN, {27'($urandom()), kmer_set[p]});
      random_phase(PHASE_ITEMS);
    end

    if (errors == 0 && pending == 0) begin
      $display("dna_minimizer_sketcher_test: done, clean");
    end else begin
      $display("dna_minimizer_sketcher_test: done, errors");
    end
    $finish;
  end

endmodule
